[rtl/ica_pkg.sv]
// ica_pkg: shared types, codes and constants for the integer arithmetic unit
// no dependencies
`default_nettype none
package ica_pkg;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OP_W = 3;
  localparam int unsigned ST_W = 3;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_POW = 3'd4, OP_SQRT = 3'd5, OP_REM = 3'd6, OP_INV = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK = 3'd0, ST_OVF = 3'd1, ST_DIV0 = 3'd2, ST_NEGROOT = 3'd3, ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_DIV   = 3'd2,
    CMD_SQRT  = 3'd3,
    CMD_MUL   = 3'd4,
    CMD_POW   = 3'd5,
    CMD_FIN   = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ica_ctl_t;

  typedef struct packed {
    logic step_done;
    logic pow_done;
  } ica_sts_t;
endpackage
`default_nettype wire

[rtl/ica_ctrl.sv]
// ica_ctrl: controller state machine sequencing the datapath
// depends on ica_pkg
`default_nettype none
module ica_ctrl
  import ica_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire op_t      op,
  input  wire logic     out_free,
  input  wire ica_sts_t sts,
  output logic          in_tready,
  output ica_ctl_t      ctl
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_ITER = 6'b000010, S_MUL = 6'b000100,
    S_POW  = 6'b001000, S_FIN  = 6'b010000, S_WAIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.cmd   = CMD_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          ctl.cmd = CMD_LOAD;
          unique case (op) inside
            OP_DIV, OP_REM, OP_SQRT: state_nxt = S_ITER;
            OP_MUL:                  state_nxt = S_MUL;
            OP_POW:                  state_nxt = S_POW;
            default:                 state_nxt = S_FIN;
          endcase
        end
      end
      S_ITER: begin
        ctl.cmd = (op_r == OP_SQRT) ? CMD_SQRT : CMD_DIV;
        if (sts.step_done) state_nxt = S_FIN;
      end
      S_MUL: begin
        ctl.cmd   = CMD_MUL;
        state_nxt = S_FIN;
      end
      S_POW: begin
        ctl.cmd = CMD_POW;
        if (sts.pow_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.cmd   = CMD_FIN;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          ctl.cmd   = CMD_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/ica_dp.sv]
// ica_dp: operand registers, restoring divider, root unit, multiplier, power loop
// depends on ica_pkg
`default_nettype none
module ica_dp
  import ica_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire ica_ctl_t              ctl,
  input  wire op_t                   op,
  input  wire logic [DATA_WIDTH-1:0] a_in,
  input  wire logic [DATA_WIDTH-1:0] b_in,
  output ica_sts_t                   sts,
  output logic [DATA_WIDTH-1:0]      res_val,
  output status_t                    res_st
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] mx, mn;
  assign mx = {1'b0, {(W-1){1'b1}}};
  assign mn = {1'b1, {(W-1){1'b0}}};

  op_t          op_r;
  logic [W-1:0] a_r, b_r;
  logic         an_r, bn_r;
  logic [W-1:0] ma_r, mb_r;

  // divider / root
  logic [W-1:0]  q_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  root_r;
  logic [W+1:0]  srem_r;

  // multiply / power
  logic [2*W-1:0] prod_r;
  logic [W:0]     acc_r, base_r;
  logic [W-1:0]   e_r;
  logic           pneg_r;
  logic           pphase_r;
  logic [W:0]     cap;

  logic [W:0]   rtrial;
  logic [W+1:0] strial;
  logic         pstep_done;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  assign cap    = pneg_r ? {1'b0, mn} : {1'b0, mx};
  assign rtrial = {rem_r, q_r[W-1]} - {1'b0, mb_r};
  assign strial = {srem_r[W-1:0], a_r[W-1-2*cnt_r[CW-2:0] -: 2]} - {root_r, 2'b01};

  // power uses one shared multiplier, registered result each step
  logic [W:0]     mx_a, mx_b;
  logic [2*W+1:0] pm;
  logic [W:0]     pm_cap;
  assign mx_a   = pphase_r ? base_r : acc_r;
  assign mx_b   = base_r;
  assign pm     = mx_a * mx_b;
  assign pm_cap = (pm > {{(W+1){1'b0}}, cap}) ? cap + 1'b1 : pm[W:0];
  assign pstep_done = (e_r == '0) && !pphase_r;

  assign sts.step_done = (cnt_r == CW'(W/2 - 1) && op_r == OP_SQRT)
                       || (cnt_r == CW'(W - 1) && op_r != OP_SQRT);
  assign sts.pow_done  = pstep_done;

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_LOAD: begin
        op_r   <= op;
        a_r    <= a_in;
        b_r    <= b_in;
        an_r   <= a_in[W-1];
        bn_r   <= b_in[W-1];
        ma_r   <= mag(a_in);
        mb_r   <= mag(b_in);
        q_r    <= mag(a_in);
        rem_r  <= '0;
        cnt_r  <= '0;
        root_r <= '0;
        srem_r <= '0;
        acc_r  <= {{W{1'b0}}, 1'b1};
        e_r    <= b_in;
        pneg_r <= a_in[W-1] & b_in[0];
        pphase_r <= 1'b0;
        base_r <= {1'b0, mag(a_in)};
      end
      CMD_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (!rtrial[W]) begin
          rem_r <= rtrial[W-1:0];
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-2:0], q_r[W-1]};
          q_r   <= {q_r[W-2:0], 1'b0};
        end
      end
      CMD_SQRT: begin
        cnt_r <= cnt_r + 1'b1;
        if (!strial[W+1]) begin
          srem_r <= strial;
          root_r <= {root_r[W-2:0], 1'b1};
        end else begin
          srem_r <= {srem_r[W-1:0], a_r[W-1-2*cnt_r[CW-2:0] -: 2]};
          root_r <= {root_r[W-2:0], 1'b0};
        end
      end
      CMD_MUL: begin
        prod_r <= ma_r * mb_r;
      end
      CMD_POW: begin
        // alternate: multiply acc when exponent bit set, then square base
        if (!pphase_r) begin
          if (e_r != '0) begin
            if (e_r[0]) acc_r <= pm_cap;
            pphase_r <= 1'b1;
          end
        end else begin
          e_r      <= e_r >> 1;
          if ((e_r >> 1) != '0) base_r <= pm_cap;
          pphase_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // final result selection
  logic [W:0]   sum;
  logic [W-1:0] sq, rq;
  logic         pneg;
  logic [W-1:0] mcap;
  always_comb begin
    res_val = '0;
    res_st  = ST_OK;
    sum     = '0;
    sq      = q_r;
    rq      = rem_r;
    pneg    = an_r ^ bn_r;
    mcap    = pneg ? mn : mx;
    case (op_r) inside
      OP_ADD, OP_SUB: begin
        sum = (op_r == OP_ADD) ? ({a_r[W-1], a_r} + {b_r[W-1], b_r})
                               : ({a_r[W-1], a_r} - {b_r[W-1], b_r});
        if (sum[W] != sum[W-1]) begin
          res_st  = ST_OVF;
          res_val = sum[W] ? mn : mx;
        end else begin
          res_val = sum[W-1:0];
        end
      end
      OP_MUL: begin
        if (prod_r > {{W{1'b0}}, mcap}) begin
          res_st  = ST_OVF;
          res_val = pneg ? mn : mx;
        end else begin
          res_val = pneg ? (~prod_r[W-1:0] + 1'b1) : prod_r[W-1:0];
        end
      end
      OP_DIV: begin
        if (b_r == '0) res_st = ST_DIV0;
        else if (a_r == mn && b_r == '1) begin
          res_st  = ST_OVF;
          res_val = mx;
        end else res_val = pneg ? (~sq + 1'b1) : sq;
      end
      OP_REM: begin
        if (b_r == '0) res_st = ST_DIV0;
        else if (b_r == '1) res_val = '0;
        else res_val = an_r ? (~rq + 1'b1) : rq;
      end
      OP_SQRT: begin
        if (an_r) res_st = ST_NEGROOT;
        else res_val = root_r;
      end
      OP_POW: begin
        if (bn_r) begin
          if (a_r == '0) res_st = ST_DIV0;
          else if (a_r == {{(W-1){1'b0}}, 1'b1}) res_val = {{(W-1){1'b0}}, 1'b1};
          else if (a_r == '1) res_val = b_r[0] ? '1 : {{(W-1){1'b0}}, 1'b1};
          else res_val = '0;
        end else if (acc_r > cap) begin
          res_st  = ST_OVF;
          res_val = pneg_r ? mn : mx;
        end else begin
          res_val = pneg_r ? (~acc_r[W-1:0] + 1'b1) : acc_r[W-1:0];
        end
      end
      default: res_st = ST_INVALID;
    endcase
  end
endmodule
`default_nettype wire

[rtl/integer_calculator_alu_core.sv]
// integer_calculator_alu_core: top level of the integer arithmetic unit
// depends on ica_pkg, ica_ctrl, ica_dp
//
//  channel  | ports                       | contents
//  in_      | tvalid tready tdata[71:0]   | operation, operand_a, operand_b
//  out_     | tvalid tready tdata[39:0]   | result_value, status_code
//
// one item at a time: add/sub/invalid go straight to finish, mul through its multiply
// state, div/rem and root through the iterative step state, power through the
// square-and-multiply loop over the exponent bits (negative exponents run it all)
// the output register frees the core as soon as a result is loaded; a stalled
// output holds the next result in the finish or wait state with in_tready low
// synchronous active-low reset clears control only
`default_nettype none
module integer_calculator_alu_core
  import ica_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // operation[2:0], operand_a[34:3], operand_b[66:35]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // result_value[31:0], status_code[34:32]
);
  ica_ctl_t ctl;
  ica_sts_t sts;
  logic     in_fire, out_free;
  logic [DATA_WIDTH-1:0] a_w, b_w, res_val;
  status_t  res_st;
  op_t      op;
  logic [FIELD_W-1:0] val_r;
  status_t  st_r;

  assign in_fire  = in_tvalid & in_tready;
  assign out_free = !out_tvalid || out_tready;
  assign op       = op_t'(in_tdata[2:0]);
  assign a_w      = DATA_WIDTH'(in_tdata[34:3]);
  assign b_w      = DATA_WIDTH'(in_tdata[66:35]);

  ica_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .op, .out_free, .sts, .in_tready, .ctl
  );

  ica_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .ctl, .op, .a_in(a_w), .b_in(b_w), .sts, .res_val, .res_st
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (ctl.cmd == CMD_FIN) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_FIN) begin
      val_r <= FIELD_W'(res_val);
      st_r  <= res_st;
    end
  end

  logic unused_in;
  assign unused_in = ^in_tdata[71:67];

  assign out_tdata = {5'd0, st_r, val_r};
endmodule
`default_nettype wire

[tb/integer_calculator_alu_core_chk.sv]
// checker for integer_calculator_alu_core: watches both channels, predicts each result
// from the accepted item and compares value and status; depends on ica_pkg
`timescale 1ns / 100ps
module integer_calculator_alu_core_chk
  import ica_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  output int               errors,
  output int               pending
);
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  logic [34:0] result_q[$];

  function automatic logic [63:0] capped_mul(logic [63:0] x, logic [63:0] y,
                                             logic [63:0] cap);
    if (x != 0 && y > cap / x) return cap + 1;
    return (x * y > cap) ? cap + 1 : x * y;
  endfunction

  function automatic longint mag_to_signed(logic [63:0] m, bit neg);
    if (!neg) return longint'(m);
    return -longint'(m);
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [34:0] alu_result(op_t op, longint a, longint b);
    longint v;
    status_t st;
    bit neg;
    logic [63:0] cap;
    logic [63:0] p;
    logic [63:0] bs;
    logic [63:0] e;
    v = 0;
    st = ST_OK;
    case (op)
      OP_ADD: begin
        if (a + b > MAXV) begin v = MAXV; st = ST_OVF; end
        else if (a + b < MINV) begin v = MINV; st = ST_OVF; end
        else v = a + b;
      end
      OP_SUB: begin
        if (a - b > MAXV) begin v = MAXV; st = ST_OVF; end
        else if (a - b < MINV) begin v = MINV; st = ST_OVF; end
        else v = a - b;
      end
      OP_MUL: begin
        if (a * b > MAXV) begin v = MAXV; st = ST_OVF; end
        else if (a * b < MINV) begin v = MINV; st = ST_OVF; end
        else v = a * b;
      end
      OP_DIV: begin
        if (b == 0) st = ST_DIV0;
        else if (a == MINV && b == -1) begin v = MAXV; st = ST_OVF; end
        else v = a / b;
      end
      OP_REM: begin
        if (b == 0) st = ST_DIV0;
        else if (b == -1) v = 0;
        else v = a % b;
      end
      OP_SQRT: begin
        if (a < 0) st = ST_NEGROOT;
        else v = longint'(floor_root(a));
      end
      OP_POW: begin
        if (b < 0) begin
          if (a == 0) st = ST_DIV0;
          else if (a == 1) v = 1;
          else if (a == -1) v = b[0] ? -1 : 1;
        end else begin
          neg = a < 0 && b[0];
          cap = neg ? 64'd2147483648 : 64'd2147483647;
          p = 1;
          bs = a < 0 ? -a : a;
          if (bs > cap) bs = cap + 1;
          e = b;
          while (e != 0) begin
            if (e[0]) p = capped_mul(p, bs, cap);
            e = e >> 1;
            if (e != 0) bs = capped_mul(bs, bs, cap);
          end
          if (p > cap) begin v = neg ? MINV : MAXV; st = ST_OVF; end
          else v = mag_to_signed(p, neg);
        end
      end
      default: st = ST_INVALID;
    endcase
    return {st, v[31:0]};
  endfunction

  logic [34:0] want;
  int          bad;

  always @(posedge clk) begin
    if (!rst_n) begin
      errors <= 0;
    end else begin
      bad = 0;
      if (in_tvalid && in_tready)
        result_q.push_back(alu_result(op_t'(in_tdata[2:0]),
                                      longint'($signed(in_tdata[34:3])),
                                      longint'($signed(in_tdata[66:35]))));
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%t unexpected result: expected none actual %h", $time, out_tdata);
          bad = bad + 1;
        end else begin
          want = result_q.pop_front();
          if (out_tdata[31:0] !== want[31:0]) begin
            $display("%t result_value: expected %h actual %h", $time, want[31:0],
                     out_tdata[31:0]);
            bad = bad + 1;
          end
          if (out_tdata[34:32] !== want[34:32]) begin
            $display("%t status_code: expected %0d actual %0d", $time, want[34:32],
                     out_tdata[34:32]);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
    pending <= result_q.size();
  end
endmodule

[tb/integer_calculator_alu_core_tb.sv]
// top of the integer_calculator_alu_core testbench: clock, reset, stimulus and verdict
// depends on ica_pkg, integer_calculator_alu_core and integer_calculator_alu_core_chk
`timescale 1ns / 100ps
module integer_calculator_alu_core_tb;
  import ica_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1330;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  int errors;
  int pending;
  int idle_cycles = 0;
  bit sink_hold = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  integer_calculator_alu_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  integer_calculator_alu_core_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall per item, some stretches always ready
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) sink_hold = !sink_hold;
      gap = sink_hold ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 70) - 35;
      4: return $urandom_range(0, 131072) - 65536;
      5: return 32'h80000000 + $urandom_range(0, 3);
      6: return 32'h7fffffff - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(op_t op, logic [31:0] a, logic [31:0] b, int gap);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {5'b0, b, a, op};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    op_t op;
    logic [31:0] a;
    logic [31:0] b;
    bit src_hold;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_item(OP_ADD, 32'h7fffffff, 32'd1, 0);
    send_item(OP_ADD, 32'h80000000, 32'hffffffff, 0);
    send_item(OP_SUB, 32'h80000000, 32'd1, 0);
    send_item(OP_SUB, 32'h7fffffff, 32'hffffffff, 0);
    send_item(OP_MUL, 32'h80000000, 32'hffffffff, 0);
    send_item(OP_MUL, 32'h10000, 32'hffff8000, 0);
    send_item(OP_MUL, 32'hffffffff, 32'hffffffff, 0);
    send_item(OP_DIV, 32'd7, 32'd0, 0);
    send_item(OP_DIV, 32'h80000000, 32'hffffffff, 0);
    send_item(OP_DIV, 32'hfffffff9, 32'd2, 0);
    send_item(OP_REM, 32'hfffffff9, 32'd2, 0);
    send_item(OP_REM, 32'h80000000, 32'hffffffff, 0);
    send_item(OP_REM, 32'd5, 32'd0, 0);
    send_item(OP_POW, 32'd0, 32'd0, 0);
    send_item(OP_POW, 32'd0, 32'hffffffff, 0);
    send_item(OP_POW, 32'hffffffff, 32'hfffffffd, 0);
    send_item(OP_POW, 32'hffffffff, 32'hfffffffe, 0);
    send_item(OP_POW, 32'd1, 32'h80000000, 0);
    send_item(OP_POW, 32'd5, 32'hffffffff, 0);
    send_item(OP_POW, 32'hfffffffe, 32'd31, 0);
    send_item(OP_POW, 32'd2, 32'd31, 0);
    send_item(OP_POW, 32'd3, 32'h7fffffff, 0);
    send_item(OP_SQRT, 32'h7fffffff, 32'd0, 0);
    send_item(OP_SQRT, 32'hffffffff, 32'd0, 0);
    send_item(OP_INV, 32'hffffffff, 32'hffffffff, 0);
    src_hold = 0;
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) == 0) src_hold = !src_hold;
      op = op_t'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      if (op == OP_POW && $urandom_range(0, 2) != 0) b = $urandom_range(0, 40) - 4;
      send_item(op, a, b, src_hold ? 0 : $urandom_range(0, 14));
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
